FILE: hw/rtl/stp_pkg.sv
// Shared types and constants for the stepper trapezoid positioner.
// Used by the controller, datapath, top level and checkers.
`timescale 1ns / 1ps
`default_nettype none

package stp_pkg;

  localparam int POSITION_BITS = 16;

  typedef logic [POSITION_BITS-1:0] pos_t;

  // Register reset values
  localparam logic [7:0]  MIN_SPEED_RST     = 8'd10;
  localparam logic [7:0]  MAX_SPEED_RST     = 8'd100;
  localparam logic [15:0] SPEED_PRODUCT_RST = 16'd2550;
  localparam logic [2:0]  USTEP_SHIFT_RST   = 3'd0;

  // Quotient bits produced by the period divider
  localparam int DIV_STEPS = 8;

  typedef enum logic [1:0] {
    KIND_TICK   = 2'd0,
    KIND_TARGET = 2'd1,
    KIND_RESET  = 2'd2,
    KIND_SLEEP  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    REG_MIN_SPEED     = 2'd0,
    REG_MAX_SPEED     = 2'd1,
    REG_SPEED_PRODUCT = 2'd2,
    REG_USTEP_SHIFT   = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_DIV    = 2'd1,
    ST_PERIOD = 2'd2,
    ST_LOAD   = 2'd3
  } state_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] target;
    logic       driver_fault;
    logic [7:0] new_position;
    logic       sleep_on;
  } req_t;

  typedef struct packed {
    logic       step_level;
    logic       moving_up;
    logic       high_current;
    logic       running;
    logic [7:0] compare_period;
    logic [7:0] position;
    logic       busy_res;
    logic       sleeping;
    logic       move_started;
  } res_t;

  // Controller to datapath
  typedef struct packed {
    logic exec;
    logic div_step;
    logic period_wr;
    logic load;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_rise;
  } status_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stepper_trapezoid_positioner_top.sv
// Stepper trapezoid positioner: one result per request, one request at a time.
// The result is loaded from the load state after accept; a tick that raises the step
// line first runs the 8-step period divider and the period write. A stalled result
// holds off the load. The next request is taken only after the result is loaded.
// Reset (rst, synchronous): registers at defaults, motor stopped, driver asleep,
// high current, no result pending. Depends on stp_pkg, stp_ctrl, stp_dp.
`timescale 1ns / 1ps
`default_nettype none

module stepper_trapezoid_positioner_top (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire stp_pkg::req_t req,
  output logic               res_valid,
  input  wire logic          res_stall,
  output stp_pkg::res_t      res
);

  stp_pkg::cmd_t    cmd;
  stp_pkg::status_t status;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .status    (status),
    .cmd       (cmd)
  );

  stp_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .cmd       (cmd),
    .status    (status),
    .res       (res)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/stp_div.sv
// Restoring divider for the compare period: 16-bit numerator over 8-bit divisor,
// one quotient bit per step, result saturated to 255. Stands alone.
`timescale 1ns / 1ps
`default_nettype none

module stp_div (
  input  wire logic        clk,
  input  wire logic        init,
  input  wire logic        step,
  input  wire logic [15:0] numer,
  input  wire logic [7:0]  denom,
  output logic [7:0]       quot
);

  logic [7:0] rem;
  logic [7:0] low;
  logic [7:0] dsr;
  logic       sat;
  logic [8:0] trial;
  logic       fits;

  assign trial = {rem, low[7]};
  assign fits  = trial >= {1'b0, dsr};

  // Quotient fits 8 bits only when the high byte is below the divisor;
  // a zero divisor lands in the saturated case as well.
  always_ff @(posedge clk) begin
    if (init) begin
      rem <= numer[15:8];
      low <= numer[7:0];
      dsr <= denom;
      sat <= numer[15:8] >= denom;
    end else if (step) begin
      if (fits) begin
        rem <= 8'(trial - {1'b0, dsr});
      end else begin
        rem <= trial[7:0];
      end
      low <= {low[6:0], fits};
    end
  end

  assign quot = sat ? 8'hFF : low;

endmodule

`default_nettype wire

FILE: hw/rtl/stp_ctrl.sv
// Sequencing controller for the positioner: takes requests, runs the period
// divider, loads the result register. Depends on stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stp_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             req_valid,
  output logic                  req_stall,
  output logic                  res_valid,
  input  wire logic             res_stall,
  input  wire stp_pkg::status_t status,
  output stp_pkg::cmd_t         cmd
);

  localparam int CNT_W = $clog2(stp_pkg::DIV_STEPS);

  stp_pkg::state_t state, state_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  logic             load_ok;

  assign load_ok = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= stp_pkg::ST_IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    cmd.exec      = 1'b0;
    cmd.div_step  = 1'b0;
    cmd.period_wr = 1'b0;
    cmd.load      = 1'b0;
    req_stall     = 1'b1;
    unique case (state)
      stp_pkg::ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          cmd.exec = 1'b1;
          cnt_next = '0;
          state_next = status.tick_rise ? stp_pkg::ST_DIV : stp_pkg::ST_LOAD;
        end
      end
      stp_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next     = cnt + 1'b1;
        if (cnt == CNT_W'(stp_pkg::DIV_STEPS - 1)) begin
          state_next = stp_pkg::ST_PERIOD;
        end
      end
      stp_pkg::ST_PERIOD: begin
        cmd.period_wr = 1'b1;
        state_next    = stp_pkg::ST_LOAD;
      end
      stp_pkg::ST_LOAD: begin
        // hold until the result register is free
        if (load_ok) begin
          cmd.load   = 1'b1;
          state_next = stp_pkg::ST_IDLE;
        end
      end
      default: state_next = stp_pkg::ST_IDLE;
    endcase
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stp_dp.sv
// Datapath of the positioner: configuration registers, motion state, speed ramp,
// period divider and result register. Depends on stp_pkg and stp_div.
`timescale 1ns / 1ps
`default_nettype none

module stp_dp (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          cfg_we,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data,
  input  wire stp_pkg::req_t req,
  input  wire stp_pkg::cmd_t cmd,
  output stp_pkg::status_t   status,
  output stp_pkg::res_t      res
);

  // Configuration
  logic [7:0]  speed_floor;
  logic [7:0]  speed_ceil;
  logic [15:0] speed_product;
  logic [2:0]  ustep_shift;

  // Motion state
  stp_pkg::dir_t direction;
  stp_pkg::pos_t ustep_pos;
  logic [15:0]   steps_left;
  logic [15:0]   steps_done;
  logic [15:0]   ramp_length;
  logic [7:0]    speed_value;
  logic [7:0]    period_value;
  logic          step_line;
  logic          timer_on;
  logic          current_boost;
  logic          asleep;
  logic          started;

  // Derived values
  stp_pkg::pos_t full_shift;
  logic [7:0]    full_pos;
  stp_pkg::pos_t target_ustep;
  stp_pkg::pos_t diff;
  stp_pkg::pos_t diff_mag;
  logic [31:0]   mag_wide;
  logic [15:0]   steps_new;
  logic [7:0]    span;
  logic [15:0]   ramp_new;
  logic          set_ok;
  logic [15:0]   done_inc;
  logic [15:0]   left_dec;
  logic [7:0]    speed_rise;
  logic [7:0]    div_quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_floor   <= stp_pkg::MIN_SPEED_RST;
      speed_ceil    <= stp_pkg::MAX_SPEED_RST;
      speed_product <= stp_pkg::SPEED_PRODUCT_RST;
      ustep_shift   <= stp_pkg::USTEP_SHIFT_RST;
    end else if (cfg_we) begin
      unique case (stp_pkg::cfg_reg_t'(cfg_index))
        stp_pkg::REG_MIN_SPEED:     speed_floor   <= cfg_data[7:0];
        stp_pkg::REG_MAX_SPEED:     speed_ceil    <= cfg_data[7:0];
        stp_pkg::REG_SPEED_PRODUCT: speed_product <= cfg_data;
        stp_pkg::REG_USTEP_SHIFT:   ustep_shift   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign full_shift   = ustep_pos >> ustep_shift;
  assign full_pos     = full_shift[7:0];
  assign target_ustep = stp_pkg::pos_t'(req.target) << ustep_shift;
  assign diff         = target_ustep - ustep_pos;
  assign diff_mag     = diff[stp_pkg::POSITION_BITS-1] ? stp_pkg::pos_t'(-diff) : diff;
  assign mag_wide     = 32'(diff_mag);
  assign steps_new    = (mag_wide > 32'h0000_FFFF) ? 16'hFFFF : mag_wide[15:0];
  assign span         = (speed_ceil >= speed_floor) ? 8'(speed_ceil - speed_floor)
                                                    : 8'(speed_floor - speed_ceil);
  assign ramp_new     = ({8'd0, span} < (steps_new >> 1)) ? {8'd0, span}
                                                          : (steps_new >> 1);
  assign set_ok       = (req.target != full_pos) && (steps_left == 16'd0) &&
                        !timer_on && !req.driver_fault;

  // Ramp: accelerate inside the leading ramp, decelerate inside the trailing one
  assign done_inc = steps_done + 16'd1;
  assign left_dec = steps_left - 16'd1;
  always_comb begin
    speed_rise = speed_value;
    if ((done_inc < ramp_length) && (speed_value < speed_ceil)) begin
      speed_rise = speed_value + 8'd1;
    end else if ((left_dec < ramp_length) && (speed_value > speed_floor)) begin
      speed_rise = speed_value - 8'd1;
    end
  end

  assign status.tick_rise = (req.kind == stp_pkg::KIND_TICK) && timer_on &&
                            (steps_left != 16'd0) && !step_line;

  stp_div u_div (
    .clk   (clk),
    .init  (cmd.exec && status.tick_rise),
    .step  (cmd.div_step),
    .numer (speed_product),
    .denom (speed_rise),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      direction     <= stp_pkg::DIR_NONE;
      ustep_pos     <= '0;
      steps_left    <= '0;
      steps_done    <= '0;
      ramp_length   <= '0;
      speed_value   <= stp_pkg::MIN_SPEED_RST;
      period_value  <= '0;
      step_line     <= 1'b0;
      timer_on      <= 1'b0;
      current_boost <= 1'b1;
      asleep        <= 1'b1;
      started       <= 1'b0;
    end else begin
      if (cmd.exec) begin
        started <= 1'b0;
        unique case (req.kind)
          stp_pkg::KIND_TICK: begin
            if (timer_on) begin
              if (steps_left != 16'd0) begin
                step_line <= ~step_line;
                if (!step_line) begin
                  steps_done  <= done_inc;
                  steps_left  <= left_dec;
                  speed_value <= speed_rise;
                end
              end else begin
                // stop and commit the signed step count
                step_line     <= 1'b0;
                timer_on      <= 1'b0;
                current_boost <= 1'b0;
                steps_done    <= '0;
                if (direction == stp_pkg::DIR_UP) begin
                  ustep_pos <= ustep_pos + stp_pkg::pos_t'(steps_done);
                end else if (direction == stp_pkg::DIR_DOWN) begin
                  ustep_pos <= ustep_pos - stp_pkg::pos_t'(steps_done);
                end
              end
            end
          end
          stp_pkg::KIND_TARGET: begin
            if (set_ok) begin
              asleep <= 1'b0;
              if (diff != '0) begin
                direction     <= diff[stp_pkg::POSITION_BITS-1] ? stp_pkg::DIR_DOWN
                                                                : stp_pkg::DIR_UP;
                steps_left    <= steps_new;
                ramp_length   <= ramp_new;
                current_boost <= 1'b1;
                speed_value   <= speed_floor;
                period_value  <= speed_floor;
                timer_on      <= 1'b1;
                started       <= 1'b1;
              end
            end
          end
          stp_pkg::KIND_RESET: begin
            direction   <= stp_pkg::DIR_NONE;
            ustep_pos   <= stp_pkg::pos_t'(req.new_position) << ustep_shift;
            steps_left  <= '0;
            steps_done  <= '0;
            ramp_length <= '0;
            speed_value <= speed_floor;
          end
          stp_pkg::KIND_SLEEP: asleep <= req.sleep_on;
          default: ;
        endcase
      end
      if (cmd.period_wr) begin
        period_value <= div_quot;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      res.step_level     <= step_line;
      res.moving_up      <= direction == stp_pkg::DIR_UP;
      res.high_current   <= current_boost;
      res.running        <= timer_on;
      res.compare_period <= period_value;
      res.position       <= full_pos;
      res.busy_res       <= steps_left != 16'd0;
      res.sleeping       <= asleep;
      res.move_started   <= started;
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/stp_checker.sv
// Port-level checks for the stepper trapezoid positioner, bound to the top level.
// Depends on stp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module stp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          res_valid,
  input wire logic          res_stall,
  input wire stp_pkg::res_t res
);

  // No result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // Stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("stalled result changed");

  // Step line only high while the timer runs, and running means high current
  a_step_running: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (res.running || !res.step_level) && (!res.running || res.high_current))
    else $error("step line or current inconsistent with running");

  // A started move runs at high current with the driver awake
  a_start_state: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.move_started |-> res.running && res.high_current && !res.sleeping)
    else $error("started move not running awake at high current");

endmodule

bind stepper_trapezoid_positioner_top stp_checker u_checker (.*);

`default_nettype wire
